FILE: rtl/sbsh_pkg.sv
// Shared constants and round functions for the SHA-256 byte-stream hasher.
// Holds the round constant table, the initial hash values and the sigma helpers.
// No dependencies.
package sbsh_pkg;

    // Initial chain value, word 0 first
    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constant for round index
    function automatic logic [31:0] sbsh_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

FILE: rtl/sha256_byte_stream_hasher.sv
// SHA-256 engine fed one message byte per word, one shared round unit.
// Depends on sbsh_pkg for the round constants, initial hash and sigma functions.
//
// Usage:
//   Input channel (i_valid / o_ready) carries i_data_byte, i_byte_valid and
//   i_end_of_message. A byte word is taken whenever o_ready is high. Bytes are packed
//   big-endian into a 16-word schedule window; every 64th byte starts a
//   compression that runs one round per cycle on the shared round unit and
//   then adds the working variables into the chain value; no input is taken
//   meanwhile. An end word appends 0x80, zero words and the 64-bit bit
//   length, pushing one padding word per cycle, then runs one or two
//   compressions, each ending with the add into the chain value.
//   Output channel (o_valid / i_ready) then presents the eight digest words,
//   word index 0 first, o_last_word on the eighth. The output register holds
//   its word while the receiver stalls; no input is taken until all eight
//   words are delivered, after which the chain returns to the initial hash.
//   Reset (i_rst_n low, synchronous) clears the byte count and sequencer and
//   loads the initial hash values; no clearing pass is needed.
module sha256_byte_stream_hasher
    import sbsh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [4:0] WORDS_FULL = 5'd16;
    localparam logic [4:0] WORD_LEN_HI = 5'd14;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_INDEX = 3'd7;

    // Control state
    logic [2:0]  r_state, n_state;
    logic [60:0] r_cnt, n_cnt;
    logic [4:0]  r_wc, n_wc;
    logic [5:0]  r_rnd, n_rnd;
    logic [2:0]  r_idx, n_idx;
    logic        r_fin, n_fin;
    logic        r_mark, n_mark;
    logic        r_zero, n_zero;
    logic        r_last, n_last;
    logic [31:0] r_cv [8];
    logic [31:0] n_cv [8];

    // Payload state
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_w [16];
    logic [31:0] n_w [16];
    logic [31:0] r_v [8];
    logic [31:0] n_v [8];

    // Shared round unit and schedule expansion
    logic [31:0] t1, t2, w_new;
    logic        push;
    logic [31:0] push_word;
    logic [4:0]  wc_push;

    always_comb begin
        t1 = r_v[7] + big_s1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + sbsh_k(r_rnd) + r_w[0];
        t2 = big_s0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_new = r_w[0] + small_s0(r_w[1]) + r_w[9] + small_s1(r_w[14]);
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_digest_word = r_cv[r_idx];
    assign o_word_index = r_idx;
    assign o_last_word = (r_idx == LAST_INDEX);
    assign wc_push = r_wc + 5'd1;

    // Sequencer: pack bytes, pad, run rounds, add, emit digest
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_wc = r_wc;
        n_rnd = r_rnd;
        n_idx = r_idx;
        n_fin = r_fin;
        n_mark = r_mark;
        n_zero = r_zero;
        n_last = r_last;
        n_acc = r_acc;
        n_cv = r_cv;
        n_w = r_w;
        n_v = r_v;
        push = 1'b0;
        push_word = 32'h0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_byte_valid) begin
                        if (r_cnt[1:0] == 2'd0) begin
                            n_acc = {i_data_byte, 24'h0};
                        end else begin
                            n_acc = r_acc | ({i_data_byte, 24'h0} >> {r_cnt[1:0], 3'b000});
                        end
                        n_cnt = r_cnt + 61'd1;
                        if (r_cnt[1:0] == 2'd3) begin
                            push = 1'b1;
                            push_word = n_acc;
                        end
                    end
                    n_fin = i_end_of_message;
                    n_mark = i_end_of_message;
                    if (push && wc_push == WORDS_FULL) begin
                        n_state = S_COMP;
                        n_v = r_cv;
                        n_rnd = 6'd0;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_wc == WORDS_FULL) begin
                    n_state = S_COMP;
                    n_v = r_cv;
                    n_rnd = 6'd0;
                    n_zero = 1'b0;
                end else if (r_mark) begin
                    // Terminating 0x80 after the bytes of the partial word
                    push = 1'b1;
                    push_word = ((r_cnt[1:0] == 2'd0) ? 32'h0 : r_acc)
                              | (32'h8000_0000 >> {r_cnt[1:0], 3'b000});
                    n_mark = 1'b0;
                    if (r_wc >= WORD_LEN_HI) begin
                        n_zero = 1'b1;
                    end
                end else if (r_zero || r_wc < WORD_LEN_HI) begin
                    push = 1'b1;
                    push_word = 32'h0;
                end else if (r_wc == WORD_LEN_HI) begin
                    push = 1'b1;
                    push_word = r_cnt[60:29];
                end else begin
                    push = 1'b1;
                    push_word = {r_cnt[28:0], 3'b000};
                    n_last = 1'b1;
                end
            end
            S_COMP: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i + 1];
                end
                n_w[15] = w_new;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == LAST_ROUND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_cv[i] = r_cv[i] + r_v[i];
                end
                n_wc = 5'd0;
                if (r_last) begin
                    n_state = S_OUT;
                    n_idx = 3'd0;
                end else if (r_fin) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    if (r_idx == LAST_INDEX) begin
                        n_cv = H_INIT;
                        n_cnt = 61'd0;
                        n_fin = 1'b0;
                        n_last = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Shift a finished word into the schedule window
        if (push) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = r_w[i + 1];
            end
            n_w[15] = push_word;
            n_wc = wc_push;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= 61'd0;
            r_wc <= 5'd0;
            r_rnd <= 6'd0;
            r_idx <= 3'd0;
            r_fin <= 1'b0;
            r_mark <= 1'b0;
            r_zero <= 1'b0;
            r_last <= 1'b0;
            r_cv <= H_INIT;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_wc <= n_wc;
            r_rnd <= n_rnd;
            r_idx <= n_idx;
            r_fin <= n_fin;
            r_mark <= n_mark;
            r_zero <= n_zero;
            r_last <= n_last;
            r_cv <= n_cv;
        end
    end

    // Advance payload registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_w <= n_w;
        r_v <= n_v;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output handshakes open together");

    a_wc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wc <= WORDS_FULL)
        else $error("schedule window overfilled");

    a_comp_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_COMP && n_state == S_COMP) |-> (r_wc == WORDS_FULL || wc_push == WORDS_FULL))
        else $error("compression started on a partial block");

    a_digest_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_word) |=> (o_ready && r_cnt == 61'd0 && !r_fin))
        else $error("state not restored after digest");

    a_last_only_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_last && r_fin && !r_mark))
        else $error("digest emitted without a final block");
`endif

endmodule
